FILE: rtl/core/sda_pkg.sv
// Shared types and constants of the SPH density accumulator.
`default_nettype none
package sda_pkg;

  // Fixed-point constants in Q.16.
  localparam int unsigned OneQ16 = 65536;
  localparam int unsigned TwoQ16 = 131072;

  // Depth of the queue between the kernel pipeline and the accumulator.
  localparam int unsigned QueueDepth = 8;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Field widths.
  localparam int unsigned DistW  = 24;
  localparam int unsigned InvHW  = 24;
  localparam int unsigned NormW  = 32;
  localparam int unsigned SumW   = 48;
  localparam int unsigned PolyW  = 17;
  localparam int unsigned TermW  = 33;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_INV_H  = 2'd0,
    REG_NORM   = 2'd1,
    REG_SELF   = 2'd2
  } sda_reg_e;

  // One neighbor distance transfer.
  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             last_neighbor;
  } sda_in_t;

  // One density result.
  typedef struct packed {
    logic [SumW-1:0] density;
    logic            saturated;
  } sda_out_t;

  // Kernel term handed from the front pipeline to the accumulator.
  typedef struct packed {
    logic [TermW-1:0] term;
    logic             last;
  } sda_entry_t;

  // Current register contents.
  typedef struct packed {
    logic [InvHW-1:0] inv_h;
    logic [NormW-1:0] norm;
    logic             include_self;
  } sda_cfg_t;

endpackage
`default_nettype wire

FILE: rtl/core/sda_kernel_front.sv
// Kernel pipeline: scales a distance, classifies it and evaluates the spline term.
`default_nettype none
module sda_kernel_front
  import sda_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire sda_cfg_t   cfg_i,
  input  wire logic       accept_i,
  input  wire sda_in_t    item_i,
  input  wire logic       release_i,
  output logic            full_o,
  output logic            entry_valid_o,
  output sda_entry_t      entry_o
);

  // Stage valid bits.
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q, s6_valid_q;

  // Stage payloads.
  logic [31:0]      s1_v_q;
  logic             s1_last_q;
  logic [PolyW-1:0] s2_a_q, s3_a_q;
  logic [PolyW-1:0] s3_sq_q, s4_sq_q, s4_cube_q;
  logic [PolyW-1:0] s5_poly_q;
  logic             s2_inner_q, s3_inner_q, s4_inner_q;
  logic             s2_far_q, s3_far_q, s4_far_q;
  logic             s2_last_q, s3_last_q, s4_last_q, s5_last_q;
  logic [TermW-1:0] s6_term_q;
  logic             s6_last_q;

  // Items accepted whose term has not yet left the queue.
  logic [QueueCntW-1:0] outstanding_q, outstanding_d;

  // Combinational stage results.
  logic [47:0]      scaled;
  logic             far, inner;
  logic [17:0]      w_full;
  logic [PolyW-1:0] a_sel;
  logic [33:0]      sq_full, cube_full;
  logic [18:0]      tri_cube, tri_sq;
  logic [19:0]      pos, neg;
  logic [PolyW-1:0] poly;
  logic [48:0]      term_full;

  // Credit count bounds the items in flight by the queue depth.
  always_comb begin
    outstanding_d = outstanding_q;
    if (accept_i && !release_i) begin
      outstanding_d = outstanding_q + QueueCntW'(1);
    end else if (!accept_i && release_i) begin
      outstanding_d = outstanding_q - QueueCntW'(1);
    end
  end

  assign full_o = (outstanding_q == QueueCntW'(QueueDepth));

  // Stage 1: v = d / h as d times 1/h.
  assign scaled = 48'(item_i.distance) * 48'(cfg_i.inv_h);

  // Stage 2: region and the base value that gets cubed.
  assign far    = |s1_v_q[31:17];
  assign inner  = ~|s1_v_q[31:16];
  assign w_full = 18'(TwoQ16) - s1_v_q[17:0];
  assign a_sel  = inner ? {1'b0, s1_v_q[15:0]} : w_full[PolyW-1:0];

  // Stages 3 and 4: square, then cube.
  assign sq_full   = 34'(s2_a_q) * 34'(s2_a_q);
  assign cube_full = 34'(s3_sq_q) * 34'(s3_a_q);

  // Stage 5: spline polynomial for the inner and outer regions.
  always_comb begin
    tri_cube = {1'b0, s4_cube_q, 1'b0} + 19'(s4_cube_q);
    tri_sq   = {1'b0, s4_sq_q, 1'b0} + 19'(s4_sq_q);
    pos      = 20'(OneQ16) + 20'(tri_cube[18:2]);
    neg      = 20'(tri_sq[18:1]);
    if (s4_far_q) begin
      poly = '0;
    end else if (s4_inner_q) begin
      poly = (pos > neg) ? PolyW'(pos - neg) : '0;
    end else begin
      poly = {2'b00, s4_cube_q[PolyW-1:2]};
    end
  end

  // Stage 6: scale by the normalization.
  assign term_full = 49'(cfg_i.norm) * 49'(s5_poly_q);

  // Valid bits and the credit counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      s3_valid_q    <= 1'b0;
      s4_valid_q    <= 1'b0;
      s5_valid_q    <= 1'b0;
      s6_valid_q    <= 1'b0;
      outstanding_q <= '0;
    end else begin
      s1_valid_q    <= accept_i;
      s2_valid_q    <= s1_valid_q;
      s3_valid_q    <= s2_valid_q;
      s4_valid_q    <= s3_valid_q;
      s5_valid_q    <= s4_valid_q;
      s6_valid_q    <= s5_valid_q;
      outstanding_q <= outstanding_d;
    end
  end

  // Payload registers; the pipeline never stalls.
  always_ff @(posedge clk_i) begin
    s1_v_q     <= scaled[47:16];
    s1_last_q  <= item_i.last_neighbor;
    s2_a_q     <= a_sel;
    s2_inner_q <= inner;
    s2_far_q   <= far;
    s2_last_q  <= s1_last_q;
    s3_sq_q    <= sq_full[32:16];
    s3_a_q     <= s2_a_q;
    s3_inner_q <= s2_inner_q;
    s3_far_q   <= s2_far_q;
    s3_last_q  <= s2_last_q;
    s4_cube_q  <= cube_full[32:16];
    s4_sq_q    <= s3_sq_q;
    s4_inner_q <= s3_inner_q;
    s4_far_q   <= s3_far_q;
    s4_last_q  <= s3_last_q;
    s5_poly_q  <= poly;
    s5_last_q  <= s4_last_q;
    s6_term_q  <= term_full[48:16];
    s6_last_q  <= s5_last_q;
  end

  assign entry_valid_o = s6_valid_q;
  assign entry_o.term  = s6_term_q;
  assign entry_o.last  = s6_last_q;

`ifndef SYNTHESIS
  // The credit count never exceeds the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= QueueCntW'(QueueDepth))
    else $error("front: credit count above queue depth");

  // No transfer is taken while the credits are used up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !accept_i)
    else $error("front: item accepted without a credit");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/sda_term_queue.sv
// Short queue of kernel terms between the front pipeline and the accumulator.
`default_nettype none
module sda_term_queue
  import sda_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       wr_valid_i,
  input  wire sda_entry_t wr_entry_i,
  input  wire logic       rd_ready_i,
  output logic            rd_valid_o,
  output sda_entry_t      rd_entry_o
);

  sda_entry_t             store_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]   count_q;
  logic                   do_rd;

  assign rd_valid_o = (count_q != '0);
  assign rd_entry_o = store_q[rd_ptr_q];
  assign do_rd      = rd_ready_i && rd_valid_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_valid_i) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (wr_valid_i && !do_rd) begin
        count_q <= count_q + QueueCntW'(1);
      end else if (!wr_valid_i && do_rd) begin
        count_q <= count_q - QueueCntW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (wr_valid_i) begin
      store_q[wr_ptr_q] <= wr_entry_i;
    end
  end

`ifndef SYNTHESIS
  // Credits upstream keep the queue from overflowing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_i |-> (count_q != QueueCntW'(QueueDepth)) || do_rd)
    else $error("queue: write into a full queue");

  // Fill count agrees with the pointer distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q[QueuePtrW-1:0] == QueuePtrW'(wr_ptr_q - rd_ptr_q))
    else $error("queue: fill count and pointers disagree");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/sda_accum_back.sv
// Saturating density accumulator and result register.
`default_nettype none
module sda_accum_back
  import sda_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire sda_cfg_t   cfg_i,
  input  wire logic       head_valid_i,
  input  wire sda_entry_t head_i,
  output logic            head_ready_o,
  input  wire logic       pop_i,
  output logic            empty_o,
  output sda_out_t        out_o
);

  logic [SumW-1:0] sum_q;
  logic            clamped_q;
  logic            start_q;
  logic            res_valid_q;
  sda_out_t        res_q;

  logic            res_take;
  logic            consume;
  logic [SumW-1:0] base;
  logic [SumW:0]   sum_wide;
  logic [SumW-1:0] sum_new;
  logic            clamp_new;

  assign res_take     = pop_i && res_valid_q;
  // A closing term needs the result slot free or freed in this cycle.
  assign head_ready_o = !head_i.last || !res_valid_q || res_take;
  assign consume      = head_valid_i && head_ready_o;

  // First term of a list starts from the self term or from zero.
  always_comb begin
    if (start_q) begin
      base = cfg_i.include_self ? SumW'(cfg_i.norm) : '0;
    end else begin
      base = sum_q;
    end
    sum_wide  = {1'b0, base} + (SumW + 1)'(head_i.term);
    sum_new   = sum_wide[SumW] ? {SumW{1'b1}} : sum_wide[SumW-1:0];
    clamp_new = (clamped_q && !start_q) || sum_wide[SumW];
  end

  // List state and result flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamped_q   <= 1'b0;
      start_q     <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      if (consume) begin
        clamped_q <= clamp_new;
        start_q   <= head_i.last;
      end
      if (consume && head_i.last) begin
        res_valid_q <= 1'b1;
      end else if (res_take) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Running sum and result payload.
  always_ff @(posedge clk_i) begin
    if (consume) begin
      sum_q <= sum_new;
    end
    if (consume && head_i.last) begin
      res_q.density   <= sum_new;
      res_q.saturated <= clamp_new;
    end
  end

  assign empty_o = !res_valid_q;
  assign out_o   = res_q;

`ifndef SYNTHESIS
  // A waiting result is neither lost nor altered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !pop_i) |=> (res_valid_q && $stable(res_q)))
    else $error("back: waiting result changed before transfer");

  // A closing term is never absorbed while the result slot stays occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && head_i.last) |-> (!res_valid_q || pop_i))
    else $error("back: result overwritten");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/sph_density_accumulator_unit.sv
// Top level: configuration registers, kernel pipeline, term queue, accumulator.
// A closing distance passes stages s1 to s6 and the term queue; empty falls when it is absorbed.
// Throughput: one distance per cycle while full is low; eight credits, one per term queue
// entry, cover the loop from accept to the accumulator, and full rises when they are spent.
// Reset (rst_ni low, asynchronous): registers return to 1/h = 1.0, norm = 20861,
// include_self = 0, and the pipeline, queue and accumulator are emptied.
`default_nettype none
module sph_density_accumulator_unit
  import sda_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire sda_in_t             in_i,
  output logic                     empty,
  input  wire logic                pop,
  output sda_out_t                 out_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  sda_cfg_t   cfg_q;
  logic       accept;
  logic       entry_valid;
  sda_entry_t entry;
  logic       head_valid;
  logic       head_ready;
  sda_entry_t head;
  logic       release_credit;

  assign cfg_ready_o    = 1'b1;
  assign accept         = push && !full;
  assign release_credit = head_valid && head_ready;

  // Configuration register writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_h        <= InvHW'(OneQ16);
      cfg_q.norm         <= NormW'(20861);
      cfg_q.include_self <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (sda_reg_e'(cfg_index_i))
        REG_INV_H: cfg_q.inv_h        <= cfg_data_i[InvHW-1:0];
        REG_NORM:  cfg_q.norm         <= cfg_data_i;
        REG_SELF:  cfg_q.include_self <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sda_kernel_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .accept_i      (accept),
    .item_i        (in_i),
    .release_i     (release_credit),
    .full_o        (full),
    .entry_valid_o (entry_valid),
    .entry_o       (entry)
  );

  sda_term_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (entry_valid),
    .wr_entry_i (entry),
    .rd_ready_i (head_ready),
    .rd_valid_o (head_valid),
    .rd_entry_o (head)
  );

  sda_accum_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_ready_o (head_ready),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_o        (out_o)
  );

endmodule
`default_nettype wire
